[design/assert_macros.svh]
// Shared assertion macros. Each expands to one labeled concurrent assertion
// sampled on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication check
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[design/ols_pkg.sv]
`timescale 1ns / 1ps

package ols_pkg;

	// Default sizing
	localparam int DEPTH_DEF = 16;
	localparam int WIDTH_DEF = 32;

	// Field widths fixed by the request and response formats
	localparam int OP_W = 3;
	localparam int ST_W = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_GET    = 3'd0;
	localparam logic [OP_W-1:0] OP_SET    = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_BOUND = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// Strobes from the sequencer to the entry memory
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_cmd_t;

endpackage

[design/ols_ifs.sv]
`timescale 1ns / 1ps

// Request channel: one list operation per transaction
interface ols_req_if import ols_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WIDTH = WIDTH_DEF
) ();
	localparam int CW = $clog2(DEPTH + 1);

	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         operation;
	logic [CW-1:0]           position;
	logic signed [WIDTH-1:0] item_value;

	modport source (output valid, output operation, output position, output item_value,
		input ready);
	modport sink (input valid, input operation, input position, input item_value,
		output ready);
endinterface

// Response channel: one result per request transaction
interface ols_rsp_if import ols_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WIDTH = WIDTH_DEF
) ();
	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] read_value;
	logic                    found;
	logic [AW-1:0]           found_position;
	logic [ST_W-1:0]         status;
	logic [CW-1:0]           entry_count;

	modport source (output valid, output read_value, output found, output found_position,
		output status, output entry_count, input ready);
	modport sink (input valid, input read_value, input found, input found_position,
		input status, input entry_count, output ready);
endinterface

[design/ols_mem.sv]
`timescale 1ns / 1ps

module ols_mem import ols_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WIDTH = WIDTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  mem_cmd_t         cmd,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/ols_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ols_ctrl import ols_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WIDTH = WIDTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	ols_req_if.sink          req,
	ols_rsp_if.source        rsp,
	output mem_cmd_t         mem_cmd,
	output logic [AW-1:0]    wr_addr,
	output logic [WIDTH-1:0] wr_data,
	output logic [AW-1:0]    rd_addr,
	input  logic [WIDTH-1:0] rd_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINISH,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [OP_W-1:0]  op_q;
	logic [CW-1:0]    pos_q;
	logic [WIDTH-1:0] val_q;
	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    cur_q;
	logic [AW-1:0]    last_q;
	logic             more_q;
	logic             down_q;
	logic             pend_q;
	logic [AW-1:0]    pend_addr_q;
	logic [WIDTH-1:0] rd_val_q;
	logic             hit_q;
	logic [AW-1:0]    hit_pos_q;
	logic [ST_W-1:0]  status_q;

	logic             out_valid_q;
	logic [WIDTH-1:0] out_read_q;
	logic             out_found_q;
	logic [AW-1:0]    out_fpos_q;
	logic [ST_W-1:0]  out_status_q;
	logic [CW-1:0]    out_count_q;

	logic             req_fire;
	logic             out_free;
	logic [CW-1:0]    cnt_m1;
	logic             pos_in_list;
	logic             pos_at_end;
	logic             cmp_hit;
	logic [AW-1:0]    pos_addr;
	logic             pend_is_pos;
	logic             walk_drained;

	assign req.ready    = (state_q == S_IDLE);
	assign req_fire     = req.valid && req.ready;
	assign out_free     = !out_valid_q || rsp.ready;
	assign cnt_m1       = cnt_q - 1'b1;
	assign pos_in_list  = (req.position < cnt_q);
	assign pos_at_end   = (req.position == cnt_q);
	assign pos_addr     = pos_q[AW-1:0];
	assign pend_is_pos  = (pend_addr_q == pos_addr);
	assign walk_drained = !more_q && !pend_q;

	// Compare unit: stored word against the searched value
	assign cmp_hit = (rd_data == val_q);

	// Drive memory strobes and addresses from the sequencer state
	always_comb begin
		mem_cmd.rd_en = (state_q == S_WALK) && more_q;
		mem_cmd.wr_en = 1'b0;
		rd_addr       = cur_q;
		wr_addr       = pend_addr_q;
		wr_data       = rd_data;
		case (state_q)
			S_IDLE: begin
				mem_cmd.wr_en = req_fire && (req.operation == OP_SET) && pos_in_list;
				wr_addr       = req.position[AW-1:0];
				wr_data       = req.item_value;
			end
			S_WALK: begin
				if (pend_q && (op_q == OP_INSERT)) begin
					mem_cmd.wr_en = 1'b1;
					wr_addr       = pend_addr_q + 1'b1;
				end else if (pend_q && (op_q == OP_REMOVE) && !pend_is_pos) begin
					mem_cmd.wr_en = 1'b1;
					wr_addr       = pend_addr_q - 1'b1;
				end
			end
			S_FINISH: begin
				mem_cmd.wr_en = 1'b1;
				wr_addr       = pos_addr;
				wr_data       = val_q;
			end
			default: begin
				mem_cmd.wr_en = 1'b0;
			end
		endcase
	end

	// Sequence one request, then hold its result until the response is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			more_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a new response or drop the one just taken
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						op_q     <= req.operation;
						pos_q    <= req.position;
						val_q    <= req.item_value;
						rd_val_q <= '0;
						hit_q    <= 1'b0;
						hit_pos_q <= '0;
						pend_q   <= 1'b0;
						case (req.operation)
							OP_GET: begin
								if (!pos_in_list) begin
									status_q <= ST_BOUND;
									state_q  <= S_DONE;
								end else begin
									status_q <= ST_OK;
									cur_q   <= req.position[AW-1:0];
									last_q  <= req.position[AW-1:0];
									down_q  <= 1'b0;
									more_q  <= 1'b1;
									state_q <= S_WALK;
								end
							end
							OP_SET: begin
								status_q <= pos_in_list ? ST_OK : ST_BOUND;
								state_q  <= S_DONE;
							end
							OP_INSERT: begin
								if (!pos_in_list && !pos_at_end) begin
									status_q <= ST_BOUND;
									state_q  <= S_DONE;
								end else if (cnt_q == CW'(DEPTH)) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else if (pos_at_end) begin
									status_q <= ST_OK;
									state_q  <= S_FINISH;
								end else begin
									status_q <= ST_OK;
									cur_q   <= cnt_m1[AW-1:0];
									last_q  <= req.position[AW-1:0];
									down_q  <= 1'b1;
									more_q  <= 1'b1;
									state_q <= S_WALK;
								end
							end
							OP_REMOVE: begin
								if (!pos_in_list) begin
									status_q <= ST_BOUND;
									state_q  <= S_DONE;
								end else begin
									status_q <= ST_OK;
									cur_q   <= req.position[AW-1:0];
									last_q  <= cnt_m1[AW-1:0];
									down_q  <= 1'b0;
									more_q  <= 1'b1;
									state_q <= S_WALK;
								end
							end
							OP_SEARCH: begin
								status_q <= ST_OK;
								if (cnt_q != '0) begin
									cur_q   <= '0;
									last_q  <= cnt_m1[AW-1:0];
									down_q  <= 1'b0;
									more_q  <= 1'b1;
									state_q <= S_WALK;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								status_q <= ST_OK;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_WALK: begin
					if (pend_q && (op_q == OP_SEARCH) && cmp_hit) begin
						// Stop the walk at the first matching entry
						hit_q     <= 1'b1;
						hit_pos_q <= pend_addr_q;
						more_q    <= 1'b0;
						pend_q    <= 1'b0;
						state_q   <= S_DONE;
					end else begin
						// Advance the read pointer, one entry per cycle
						pend_q <= more_q;
						if (more_q) begin
							pend_addr_q <= cur_q;
							if (cur_q == last_q) begin
								more_q <= 1'b0;
							end else if (down_q) begin
								cur_q <= cur_q - 1'b1;
							end else begin
								cur_q <= cur_q + 1'b1;
							end
						end
					end
					// Consume the word read in the previous cycle
					if (pend_q && ((op_q == OP_GET) ||
						((op_q == OP_REMOVE) && pend_is_pos))) begin
						rd_val_q <= rd_data;
					end
					if (walk_drained) begin
						if (op_q == OP_INSERT) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_DONE;
						end
						if (op_q == OP_REMOVE) begin
							cnt_q <= cnt_m1;
						end
					end
				end
				S_FINISH: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_read_q   <= rd_val_q;
						out_found_q  <= hit_q;
						out_fpos_q   <= hit_pos_q;
						out_status_q <= status_q;
						out_count_q  <= cnt_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.read_value     = out_read_q;
	assign rsp.found          = out_found_q;
	assign rsp.found_position = out_fpos_q;
	assign rsp.status         = out_status_q;
	assign rsp.entry_count    = out_count_q;

	`ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CW'(DEPTH))
	`ASSERT_IMP(a_idle_drained, state_q == S_IDLE, !more_q && !pend_q)
	`ASSERT_NXT(a_cnt_hold_idle, state_q == S_IDLE, cnt_q == $past(cnt_q))
	`ASSERT_IMP(a_wr_in_range, mem_cmd.wr_en, {1'b0, wr_addr} < (AW + 1)'(DEPTH))
	`ASSERT_NXT(a_rsp_after_done, (state_q == S_DONE) && out_free, rsp.valid)

endmodule

[design/ordered_list_store_top.sv]
`timescale 1ns / 1ps
// Channel | Dir | Payload                                                   | Handshake
// req     | in  | operation, position, item_value                           | valid/ready
// rsp     | out | read_value, found, found_position, status, entry_count    | valid/ready
//
// Request paths: set, unused codes, empty search and rejected requests go straight to
// the result; get reads a single entry; insert at the end goes straight to the final write;
// other inserts, remove and search walk n entries (<= DEPTH), search stopping at a match.
// The walk moves one entry per cycle through the entry memory (one read, one write port).
// Reset clears the state, entry count, walk flags and response valid; the entry memory is not cleared.
// A stalled response is held in its output register; the next request is taken
// meanwhile and its result waits until the held one is taken.
module ordered_list_store_top import ols_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ols_req_if.sink   req,
	ols_rsp_if.source rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	mem_cmd_t         mem_cmd;
	logic [AW-1:0]    wr_addr;
	logic [WIDTH-1:0] wr_data;
	logic [AW-1:0]    rd_addr;
	logic [WIDTH-1:0] rd_data;

	ols_ctrl #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.mem_cmd (mem_cmd),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ols_mem #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.cmd     (mem_cmd),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
